[src/nbvt_pkg.sv]
// shared types, widths, cordic angle table and rounding helpers
// for the ned body velocity transform; no dependencies
package nbvt_pkg;

    localparam int VEL_WIDTH     = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int COURSE_WIDTH  = 16;
    localparam int CORDIC_STAGES = 30;
    localparam int SC_WIDTH      = 32;
    localparam int RW            = 32;
    localparam int CW            = 34;
    localparam int SQ_BITS       = 32;

    localparam logic signed [63:0] CORDIC_GAIN  = 64'sd652032874;
    localparam logic signed [63:0] VEL_MAX      = (64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VEL_MIN      = -(64'sd1 <<< (VEL_WIDTH - 1));
    localparam logic signed [63:0] COURSE_LIMIT = 64'sd18000;
    localparam logic signed [63:0] DEG_SCALE    = 64'sd36000;
    localparam logic signed [CW-1:0] QUARTER    = CW'(64'sd1073741824);

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0]   surge_rel;
        logic signed [VEL_WIDTH-1:0]   sway_rel;
        logic signed [VEL_WIDTH-1:0]   heave_rel;
        logic signed [VEL_WIDTH-1:0]   current_north;
        logic signed [VEL_WIDTH-1:0]   current_east;
        logic signed [VEL_WIDTH-1:0]   current_down;
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    } nbvt_in_t;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0]    vel_north;
        logic signed [VEL_WIDTH-1:0]    vel_east;
        logic signed [VEL_WIDTH-1:0]    vel_down;
        logic        [VEL_WIDTH-1:0]    ground_speed;
        logic signed [COURSE_WIDTH-1:0] course_deg;
        logic signed [VEL_WIDTH-1:0]    vel_surge;
        logic signed [VEL_WIDTH-1:0]    vel_sway;
        logic signed [VEL_WIDTH-1:0]    vel_heave;
    } nbvt_out_t;

    function automatic logic signed [31:0] atan_phase(input int i);
        logic signed [31:0] a;
        case (i)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            24:      a = 32'sd41;
            25:      a = 32'sd20;
            26:      a = 32'sd10;
            27:      a = 32'sd5;
            28:      a = 32'sd3;
            29:      a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // floor(x / 2^n + 1/2)
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [VEL_WIDTH-1:0] sat_vel(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > VEL_MAX) ? VEL_MAX : ((v < VEL_MIN) ? VEL_MIN : v);
        return c[VEL_WIDTH-1:0];
    endfunction

endpackage

[src/nbvt_sincos.sv]
// three-lane pipelined rotation cordic giving sine and cosine in q30
// depends on nbvt_pkg
module nbvt_sincos import nbvt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ANGLE_WIDTH-1:0]     angle [3],
    output logic                       out_valid,
    output logic signed [SC_WIDTH-1:0] sin_val [3],
    output logic signed [SC_WIDTH-1:0] cos_val [3]
);

    localparam int NS = CORDIC_STAGES;

    logic signed [CW-1:0] x_reg [3][NS+1];
    logic signed [CW-1:0] y_reg [3][NS+1];
    logic signed [CW-1:0] z_reg [3][NS+1];
    logic                 flip_reg [3][NS+1];
    logic signed [SC_WIDTH-1:0] sin_reg [3];
    logic signed [SC_WIDTH-1:0] cos_reg [3];
    logic [NS+1:0]        vld_reg;

    logic [31:0]          phase_next [3];
    logic                 flip_next [3];

    // fold the phase into the right half plane
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [31:0] ph;
            logic [31:0] plus;
            ph            = {angle[k], {(32 - ANGLE_WIDTH){1'b0}}};
            plus          = ph + 32'h4000_0000;
            flip_next[k]  = plus[31];
            phase_next[k] = plus[31] ? (ph + 32'h8000_0000) : ph;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            x_reg[k][0]    <= CW'(CORDIC_GAIN);
            y_reg[k][0]    <= '0;
            z_reg[k][0]    <= CW'(signed'(phase_next[k]));
            flip_reg[k][0] <= flip_next[k];
            for (int i = 0; i < NS; i++)
            begin
                if (z_reg[k][i] >= 0)
                begin
                    x_reg[k][i+1] <= x_reg[k][i] - (y_reg[k][i] >>> i);
                    y_reg[k][i+1] <= y_reg[k][i] + (x_reg[k][i] >>> i);
                    z_reg[k][i+1] <= z_reg[k][i] - CW'(atan_phase(i));
                end
                else
                begin
                    x_reg[k][i+1] <= x_reg[k][i] + (y_reg[k][i] >>> i);
                    y_reg[k][i+1] <= y_reg[k][i] - (x_reg[k][i] >>> i);
                    z_reg[k][i+1] <= z_reg[k][i] + CW'(atan_phase(i));
                end
                flip_reg[k][i+1] <= flip_reg[k][i];
            end
            cos_reg[k] <= flip_reg[k][NS] ? SC_WIDTH'(-x_reg[k][NS]) : SC_WIDTH'(x_reg[k][NS]);
            sin_reg[k] <= flip_reg[k][NS] ? SC_WIDTH'(-y_reg[k][NS]) : SC_WIDTH'(y_reg[k][NS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NS+1];
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;

endmodule

[src/nbvt_polar.sv]
// pipelined ground speed (bitwise square root) and course (vectoring cordic)
// depends on nbvt_pkg
module nbvt_polar import nbvt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [VEL_WIDTH-1:0]    north,
    input  logic signed [VEL_WIDTH-1:0]    east,
    output logic                           out_valid,
    output logic [VEL_WIDTH-1:0]           speed,
    output logic signed [COURSE_WIDTH-1:0] course
);

    localparam int NS  = CORDIC_STAGES;
    localparam int LAT = SQ_BITS + 3;

    // course path
    logic signed [63:0]   cx_reg [NS+1];
    logic signed [63:0]   cy_reg [NS+1];
    logic signed [CW-1:0] cz_reg [NS+1];
    logic                 zero_reg [NS+3];
    logic signed [63:0]   prod_reg;
    logic signed [COURSE_WIDTH-1:0] cd_reg [3];

    // speed path
    logic signed [63:0]   sqn_reg;
    logic signed [63:0]   sqe_reg;
    logic [63:0]          q_reg [SQ_BITS+1];
    logic [SQ_BITS+3:0]   rem_reg [SQ_BITS+1];
    logic [SQ_BITS-1:0]   root_reg [SQ_BITS+1];
    logic [VEL_WIDTH-1:0] speed_reg;

    logic [LAT-1:0]       vld_reg;

    logic signed [63:0]   nx;
    logic signed [63:0]   ex;
    logic signed [63:0]   cd;

    assign nx = 64'(north);
    assign ex = 64'(east);
    assign cd = rnd_shift(prod_reg, 32);

    always_ff @(posedge clk)
    begin
        // quadrant pre-rotation
        zero_reg[0] <= (north == '0) && (east == '0);
        if (north >= 0)
        begin
            cx_reg[0] <= nx <<< 28;
            cy_reg[0] <= ex <<< 28;
            cz_reg[0] <= '0;
        end
        else if (east >= 0)
        begin
            cx_reg[0] <= ex <<< 28;
            cy_reg[0] <= (-nx) <<< 28;
            cz_reg[0] <= QUARTER;
        end
        else
        begin
            cx_reg[0] <= (-ex) <<< 28;
            cy_reg[0] <= nx <<< 28;
            cz_reg[0] <= -QUARTER;
        end
        for (int i = 0; i < NS; i++)
        begin
            if (cy_reg[i] > 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + CW'(atan_phase(i));
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - CW'(atan_phase(i));
            end
        end
        for (int i = 0; i < NS + 2; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
        end
        prod_reg <= 64'(cz_reg[NS]) * DEG_SCALE;
        if (zero_reg[NS+1])
        begin
            cd_reg[0] <= '0;
        end
        else if (cd > COURSE_LIMIT)
        begin
            cd_reg[0] <= COURSE_WIDTH'(COURSE_LIMIT);
        end
        else if (cd < -COURSE_LIMIT)
        begin
            cd_reg[0] <= COURSE_WIDTH'(-COURSE_LIMIT);
        end
        else
        begin
            cd_reg[0] <= COURSE_WIDTH'(cd);
        end
        cd_reg[1] <= cd_reg[0];
        cd_reg[2] <= cd_reg[1];

        // square root rounded to nearest, one result bit a stage
        sqn_reg     <= nx * nx;
        sqe_reg     <= ex * ex;
        q_reg[0]    <= 64'(sqn_reg + sqe_reg);
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        for (int k = 0; k < SQ_BITS; k++)
        begin
            logic [SQ_BITS+3:0] rt;
            logic [SQ_BITS+3:0] tr;
            rt = {rem_reg[k][SQ_BITS+1:0], q_reg[k][63:62]};
            tr = {2'b00, root_reg[k], 2'b01};
            if (rt >= tr)
            begin
                rem_reg[k+1]  <= rt - tr;
                root_reg[k+1] <= {root_reg[k][SQ_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1]  <= rt;
                root_reg[k+1] <= {root_reg[k][SQ_BITS-2:0], 1'b0};
            end
            q_reg[k+1] <= {q_reg[k][61:0], 2'b00};
        end
        if (rem_reg[SQ_BITS] > (SQ_BITS + 4)'(root_reg[SQ_BITS]))
        begin
            speed_reg <= VEL_WIDTH'(root_reg[SQ_BITS] + 1'b1);
        end
        else
        begin
            speed_reg <= VEL_WIDTH'(root_reg[SQ_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign speed     = speed_reg;
    assign course    = cd_reg[2];

endmodule

[src/ned_body_velocity_transform.sv]
// top level: zyx euler rotation of body velocity into ned plus current,
// ground speed, course and back-rotation; uses nbvt_pkg, nbvt_sincos, nbvt_polar
//
// usage:
//   drive one beat on operand with start high; busy stays low, so a beat
//   may be issued on every clock cycle.
//   each beat yields exactly one result beat on result, marked by done
//   for one cycle.
//   throughput is one beat per cycle: every unit (three sine/cosine
//   cordics, the matrix multipliers, the vectoring cordic and the
//   square root) is fully pipelined.
//   reset clears only the valid bits; beats in flight are dropped.
//   the receiver must take done beats as they come; there is no stall.
module ned_body_velocity_transform import nbvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  nbvt_in_t  operand,
    output logic      done,
    output nbvt_out_t result
);

    localparam int SC_LAT  = CORDIC_STAGES + 2;
    localparam int BC_LEN  = SC_LAT + 4;
    localparam int NED_DLY = SQ_BITS + 3;
    localparam int BV_DLY  = NED_DLY - 2;
    localparam int LATENCY = SC_LAT + 6 + NED_DLY;

    // product and term slots
    localparam int T_CPCT = 0;
    localparam int T_SPCF = 1;
    localparam int T_SPSF = 2;
    localparam int T_SPCT = 3;
    localparam int T_CPCF = 4;
    localparam int T_CPSF = 5;
    localparam int T_CTSF = 6;
    localparam int T_CTCF = 7;

    logic [ANGLE_WIDTH-1:0]     angle [3];
    logic                       sc_valid;
    logic signed [SC_WIDTH-1:0] sin_val [3];
    logic signed [SC_WIDTH-1:0] cos_val [3];

    nbvt_in_t                   bc_reg [BC_LEN];
    logic signed [63:0]         p_reg [8];
    logic signed [63:0]         p3_reg [4];
    logic signed [SC_WIDTH-1:0] c1_reg [4];
    logic signed [SC_WIDTH-1:0] c2_reg [4];
    logic signed [SC_WIDTH-1:0] st1_reg;
    logic signed [SC_WIDTH-1:0] st2_reg;
    logic signed [SC_WIDTH-1:0] st3_reg;
    logic signed [RW-1:0]       t2a_reg [8];
    logic signed [RW-1:0]       t2b_reg [8];
    logic signed [RW-1:0]       a3_reg [4];
    logic signed [63:0]         q3_reg [4];
    logic signed [RW-1:0]       r4_reg [3][3];
    logic signed [RW-1:0]       r5_reg [3][3];
    logic signed [RW-1:0]       r6_reg [3][3];
    logic signed [63:0]         m5_reg [3][3];
    logic signed [63:0]         c5_reg [3];
    logic signed [VEL_WIDTH-1:0] ned_reg [3];
    logic signed [63:0]         bp_reg [3][3];
    logic signed [VEL_WIDTH-1:0] bv_reg [3];
    logic signed [VEL_WIDTH-1:0] nd_reg [NED_DLY][3];
    logic signed [VEL_WIDTH-1:0] bo_reg [BV_DLY][3];
    logic [5:0]                 vld_reg;

    logic signed [VEL_WIDTH-1:0] body [3];
    logic signed [VEL_WIDTH-1:0] cur [3];
    logic                       pol_valid;
    logic [VEL_WIDTH-1:0]       speed;
    logic signed [COURSE_WIDTH-1:0] course;

    assign busy     = 1'b0;
    assign angle[0] = operand.roll_angle;
    assign angle[1] = operand.pitch_angle;
    assign angle[2] = operand.yaw_angle;

    nbvt_sincos u_sincos
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .angle     (angle),
        .out_valid (sc_valid),
        .sin_val   (sin_val),
        .cos_val   (cos_val)
    );

    always_comb
    begin
        body[0] = bc_reg[BC_LEN-1].surge_rel;
        body[1] = bc_reg[BC_LEN-1].sway_rel;
        body[2] = bc_reg[BC_LEN-1].heave_rel;
        cur[0]  = bc_reg[BC_LEN-1].current_north;
        cur[1]  = bc_reg[BC_LEN-1].current_east;
        cur[2]  = bc_reg[BC_LEN-1].current_down;
    end

    // lanes: 0 roll (f), 1 pitch (t), 2 yaw (p)
    always_ff @(posedge clk)
    begin
        bc_reg[0] <= operand;
        for (int i = 1; i < BC_LEN; i++)
        begin
            bc_reg[i] <= bc_reg[i-1];
        end

        // two-factor products
        p_reg[T_CPCT] <= cos_val[2] * cos_val[1];
        p_reg[T_SPCF] <= sin_val[2] * cos_val[0];
        p_reg[T_SPSF] <= sin_val[2] * sin_val[0];
        p_reg[T_SPCT] <= sin_val[2] * cos_val[1];
        p_reg[T_CPCF] <= cos_val[2] * cos_val[0];
        p_reg[T_CPSF] <= cos_val[2] * sin_val[0];
        p_reg[T_CTSF] <= cos_val[1] * sin_val[0];
        p_reg[T_CTCF] <= cos_val[1] * cos_val[0];
        p3_reg[0]     <= cos_val[2] * sin_val[1];
        p3_reg[1]     <= sin_val[0] * sin_val[1];
        p3_reg[2]     <= sin_val[1] * sin_val[2];
        p3_reg[3]     <= cos_val[2] * cos_val[0];
        c1_reg[0]     <= sin_val[0];
        c1_reg[1]     <= sin_val[2];
        c1_reg[2]     <= cos_val[0];
        c1_reg[3]     <= sin_val[1];
        st1_reg       <= sin_val[1];

        // rounding and three-factor products
        for (int i = 0; i < 8; i++)
        begin
            t2a_reg[i] <= RW'(rnd_shift(p_reg[i], 32));
            t2b_reg[i] <= t2a_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            a3_reg[i] <= RW'(rnd_shift(p3_reg[i], 30));
            c2_reg[i] <= c1_reg[i];
            q3_reg[i] <= a3_reg[i] * c2_reg[i];
        end
        st2_reg <= st1_reg;
        st3_reg <= st2_reg;

        // rotation matrix
        r4_reg[0][0] <= t2b_reg[T_CPCT];
        r4_reg[0][1] <= RW'(64'(-t2b_reg[T_SPCF]) + rnd_shift(q3_reg[0], 32));
        r4_reg[0][2] <= RW'(64'(t2b_reg[T_SPSF]) + rnd_shift(q3_reg[3], 32));
        r4_reg[1][0] <= t2b_reg[T_SPCT];
        r4_reg[1][1] <= RW'(64'(t2b_reg[T_CPCF]) + rnd_shift(q3_reg[1], 32));
        r4_reg[1][2] <= RW'(64'(-t2b_reg[T_CPSF]) + rnd_shift(q3_reg[2], 32));
        r4_reg[2][0] <= RW'(-rnd_shift(64'(st3_reg), 2));
        r4_reg[2][1] <= t2b_reg[T_CTSF];
        r4_reg[2][2] <= t2b_reg[T_CTCF];

        // body to ned
        for (int i = 0; i < 3; i++)
        begin
            c5_reg[i] <= 64'(cur[i]) <<< 28;
            for (int j = 0; j < 3; j++)
            begin
                m5_reg[i][j] <= r4_reg[i][j] * body[j];
            end
        end
        r5_reg <= r4_reg;
        for (int i = 0; i < 3; i++)
        begin
            ned_reg[i] <= sat_vel(rnd_shift(c5_reg[i] + m5_reg[i][0] + m5_reg[i][1]
                                            + m5_reg[i][2], 28));
        end
        r6_reg <= r5_reg;

        // ned back to body
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                bp_reg[i][j] <= r6_reg[j][i] * ned_reg[j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            bv_reg[i] <= sat_vel(rnd_shift(bp_reg[i][0] + bp_reg[i][1] + bp_reg[i][2], 28));
        end

        // align with the polar unit
        nd_reg[0] <= ned_reg;
        for (int i = 1; i < NED_DLY; i++)
        begin
            nd_reg[i] <= nd_reg[i-1];
        end
        bo_reg[0] <= bv_reg;
        for (int i = 1; i < BV_DLY; i++)
        begin
            bo_reg[i] <= bo_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], sc_valid};
        end
    end

    nbvt_polar u_polar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[5]),
        .north     (ned_reg[0]),
        .east      (ned_reg[1]),
        .out_valid (pol_valid),
        .speed     (speed),
        .course    (course)
    );

    assign done = pol_valid;

    always_comb
    begin
        result.vel_north    = nd_reg[NED_DLY-1][0];
        result.vel_east     = nd_reg[NED_DLY-1][1];
        result.vel_down     = nd_reg[NED_DLY-1][2];
        result.ground_speed = speed;
        result.course_deg   = course;
        result.vel_surge    = bo_reg[BV_DLY-1][0];
        result.vel_sway     = bo_reg[BV_DLY-1][1];
        result.vel_heave    = bo_reg[BV_DLY-1][2];
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result beat missing after fixed latency");

    a_polar: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> ##NED_DLY done)
        else $error("polar unit lost alignment");

    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.vel_north == '0 && result.vel_east == '0)
        |-> (result.course_deg == '0 && result.ground_speed == '0))
        else $error("zero horizontal velocity with nonzero speed or course");

    a_course: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.course_deg <= 16'sd18000 && result.course_deg >= -16'sd18000))
        else $error("course out of range");

endmodule
